// ===== rtl/mcbr_pkg.sv =====
// Package for the multichannel bias ramp: constants, request codes and FSM type.
package mcbr_pkg;

    localparam int CHANNELS_DEF   = 32;
    localparam int LEVEL_W        = 16;
    localparam int CHAN_W         = 5;
    localparam int REQ_W          = 2;
    localparam int TDATA_W        = 24;

    localparam logic [LEVEL_W-1:0] MAX_STEP_RST = 16'd10;

    localparam logic [REQ_W-1:0] REQ_SET_TARGET = 2'd0;
    localparam logic [REQ_W-1:0] REQ_STEP       = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READBACK   = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } t_state;

endpackage

// ===== rtl/multichannel_bias_ramp_core.sv =====
// Multichannel bias ramp: slew-limited stepping of bias DAC channel levels.
//
// The block keeps, per channel, a current DAC level and a target with a pending
// flag. A set-target transaction (tuser = set target) stores a target and marks
// it pending; a readback transaction overwrites the current level. Both give no
// result. A step transaction walks all CHANNELS entries: each pending channel
// whose level differs from its target moves toward it by at most max_step codes
// and gives one result (channel, new level), in ascending channel order, with
// tlast on the final one; if nothing moved, one result with tuser = 1 (settled)
// and zero data comes out. The walk reads one channel per cycle, unless the
// output side stalls it, from the level and target memories (registered reads)
// and writes the updated level back when that channel is evaluated from the read
// registers. One moved channel is held back until the next one is found (or the
// walk ends) so tlast can be set on it. max_step is written through the cfg port;
// the user must do so only while the block is idle; the block does not enforce it.
module multichannel_bias_ramp_core #(
    parameter int CHANNELS = mcbr_pkg::CHANNELS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: max_step
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    // request stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // [4:0] channel, [20:5] value, [23:21] zero
    input  logic [1:0]  i_s_tuser,   // [1:0] req_type
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [4:0] out_channel, [20:5] new_level, [23:21] zero
    output logic        o_m_tlast,   // last_update
    output logic        o_m_tuser    // [0] settled
);

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CW = $clog2(CHANNELS + 1);
    localparam int LW = mcbr_pkg::LEVEL_W;
    localparam int NW = mcbr_pkg::CHAN_W;

    // ---------------------------------------------------------------- state
    mcbr_pkg::t_state r_state, n_state;

    logic [LW-1:0]       r_max_step;
    logic [CHANNELS-1:0] r_pend;       // target pending flags
    logic [CHANNELS-1:0] r_lvl_vld;    // level entry written since reset

    // memories
    logic [LW-1:0] r_lvl_mem [CHANNELS];
    logic [LW-1:0] r_tgt_mem [CHANNELS];
    logic [LW-1:0] r_lvl_q;
    logic [LW-1:0] r_tgt_q;

    // walk control
    logic [CW-1:0] r_rd_idx;    // next channel to read
    logic [AW-1:0] r_ev_idx;    // channel whose data sits in the read registers
    logic          r_ev_vld;

    // held result (last moved channel seen so far)
    logic          r_hold_vld;
    logic [AW-1:0] r_hold_idx;
    logic [LW-1:0] r_hold_lvl;

    // output register
    logic          r_out_vld;
    logic [NW-1:0] r_out_chan;
    logic [LW-1:0] r_out_lvl;
    logic          r_out_last;
    logic          r_out_settled;

    // ---------------------------------------------------------------- input decode
    logic [NW-1:0]     in_chan;
    logic [LW-1:0]     in_val;
    logic [1:0]        in_req;
    logic              in_acc;
    logic              in_chan_ok;
    logic [AW-1:0]     in_addr;

    assign in_chan    = i_s_tdata[NW-1:0];
    assign in_val     = i_s_tdata[NW+LW-1:NW];
    assign in_req     = i_s_tuser;
    assign in_acc     = i_s_tvalid & o_s_tready;
    assign in_chan_ok = (32'(in_chan) < CHANNELS);
    assign in_addr    = AW'(in_chan);

    logic set_we, rb_we, step_go;
    assign set_we  = in_acc && (in_req == mcbr_pkg::REQ_SET_TARGET) && in_chan_ok;
    assign rb_we   = in_acc && (in_req == mcbr_pkg::REQ_READBACK) && in_chan_ok;
    assign step_go = in_acc && (in_req == mcbr_pkg::REQ_STEP);

    // ---------------------------------------------------------------- channel evaluation
    logic [LW-1:0] lvl_cur, diff, stp, lvl_new;
    logic          up, mv, out_free, stall;

    assign lvl_cur  = r_lvl_vld[r_ev_idx] ? r_lvl_q : '0;
    assign up       = r_tgt_q > lvl_cur;
    assign diff     = up ? (r_tgt_q - lvl_cur) : (lvl_cur - r_tgt_q);
    assign stp      = (diff > r_max_step) ? r_max_step : diff;
    assign lvl_new  = up ? (lvl_cur + stp) : (lvl_cur - stp);
    assign mv       = r_ev_vld && r_pend[r_ev_idx] && (r_tgt_q != lvl_cur)
                      && (r_max_step != '0);
    assign out_free = ~r_out_vld | i_m_tready;
    // a second moved channel needs the output register for the held one
    assign stall    = mv & r_hold_vld & ~out_free;

    logic rd_left, walk_done;
    assign rd_left   = r_rd_idx < CW'(CHANNELS);
    assign walk_done = ~rd_left & ~r_ev_vld;

    // ---------------------------------------------------------------- FSM
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mcbr_pkg::ST_IDLE:   if (step_go) n_state = mcbr_pkg::ST_WALK;
            mcbr_pkg::ST_WALK:   if (walk_done) n_state = mcbr_pkg::ST_FINISH;
            mcbr_pkg::ST_FINISH: if (out_free) n_state = mcbr_pkg::ST_IDLE;
            default:             n_state = mcbr_pkg::ST_IDLE;
        endcase
    end

    logic rd_go, ev_go, fin_ld;
    always_comb begin
        o_s_tready = 1'b0;
        rd_go      = 1'b0;
        ev_go      = 1'b0;
        fin_ld     = 1'b0;
        unique case (r_state)
            mcbr_pkg::ST_IDLE:   o_s_tready = 1'b1;
            mcbr_pkg::ST_WALK: begin
                rd_go = ~stall & rd_left;
                ev_go = ~stall;
            end
            mcbr_pkg::ST_FINISH: fin_ld = out_free;
            default: ;
        endcase
    end

    logic mv_wr, push_hold;
    assign mv_wr     = ev_go & mv;
    assign push_hold = mv_wr & r_hold_vld;

    assign o_cfg_ready = 1'b1;

    // ---------------------------------------------------------------- memories
    logic          lvl_we;
    logic [AW-1:0] lvl_wa;
    logic [LW-1:0] lvl_wd;
    logic [AW-1:0] rd_addr;

    assign lvl_we  = rb_we | mv_wr;
    assign lvl_wa  = rb_we ? in_addr : r_ev_idx;
    assign lvl_wd  = rb_we ? in_val : lvl_new;
    assign rd_addr = r_rd_idx[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (lvl_we) begin
            r_lvl_mem[lvl_wa] <= lvl_wd;
        end
        if (rd_go) begin
            r_lvl_q <= r_lvl_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (set_we) begin
            r_tgt_mem[in_addr] <= in_val;
        end
        if (rd_go) begin
            r_tgt_q <= r_tgt_mem[rd_addr];
        end
    end

    // ---------------------------------------------------------------- control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= mcbr_pkg::ST_IDLE;
            r_max_step <= mcbr_pkg::MAX_STEP_RST;
            r_pend     <= '0;
            r_lvl_vld  <= '0;
            r_rd_idx   <= '0;
            r_ev_vld   <= 1'b0;
            r_hold_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_max_step <= i_cfg_data;
            end
            if (set_we) begin
                r_pend[in_addr] <= 1'b1;
            end
            if (lvl_we) begin
                r_lvl_vld[lvl_wa] <= 1'b1;
            end
            if (step_go) begin
                r_rd_idx <= '0;
                r_ev_vld <= 1'b0;
            end else if (ev_go) begin
                r_ev_vld <= rd_go;
                if (rd_go) begin
                    r_rd_idx <= r_rd_idx + 1'b1;
                end
            end
            if (mv_wr) begin
                r_hold_vld <= 1'b1;
            end else if (fin_ld) begin
                r_hold_vld <= 1'b0;
            end
            if (push_hold | fin_ld) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- payload registers
    always_ff @(posedge i_clk) begin
        if (rd_go) begin
            r_ev_idx <= rd_addr;
        end
        if (mv_wr) begin
            r_hold_idx <= r_ev_idx;
            r_hold_lvl <= lvl_new;
        end
        if (push_hold) begin
            r_out_chan    <= NW'(r_hold_idx);
            r_out_lvl     <= r_hold_lvl;
            r_out_last    <= 1'b0;
            r_out_settled <= 1'b0;
        end else if (fin_ld) begin
            // final transaction of the step: held channel with tlast, or settled
            r_out_chan    <= r_hold_vld ? NW'(r_hold_idx) : '0;
            r_out_lvl     <= r_hold_vld ? r_hold_lvl : '0;
            r_out_last    <= r_hold_vld;
            r_out_settled <= ~r_hold_vld;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {3'b000, r_out_lvl, r_out_chan};
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_settled;

endmodule

// ===== tb/mcbr_ramp_checker.sv =====
// Checker for the bias ramp core: tracks channel state, predicts results, compares them.
module mcbr_ramp_checker
    import mcbr_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [15:0] i_cfg_data,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [23:0] i_s_tdata,   // [4:0] channel, [20:5] value, [23:21] zero
    input  logic [1:0]  i_s_tuser,   // [1:0] req_type
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [23:0] i_m_tdata,   // [4:0] out_channel, [20:5] new_level, [23:21] zero
    input  logic        i_m_tlast,
    input  logic        i_m_tuser,   // [0] settled
    output int          o_fail_count,
    output int          o_outstanding
);

    typedef struct {
        logic [CHAN_W-1:0]  chan;
        logic [LEVEL_W-1:0] level;
        logic               last;
        logic               settled;
    } t_ramp_update;

    logic [LEVEL_W-1:0] chan_level  [CHANNELS];
    logic [LEVEL_W-1:0] chan_target [CHANNELS];
    logic               target_armed[CHANNELS];
    logic [LEVEL_W-1:0] max_step_cfg;
    t_ramp_update       level_updates[$];

    initial o_fail_count = 0;

    task automatic check_field(input string what, input logic [31:0] expd,
                               input logic [31:0] got);
        if (got !== expd) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, expd, got);
            o_fail_count++;
        end
    endtask

    // One request transaction: store target, load level, or walk all channels once.
    task automatic apply_request(input logic [1:0] kind, input logic [CHAN_W-1:0] chan,
                                 input logic [LEVEL_W-1:0] code);
        int           delta;
        int           lim;
        int           moved;
        t_ramp_update upd;
        case (kind)
            REQ_SET_TARGET: begin
                if (chan < CHANNELS) begin
                    chan_target[chan]  = code;
                    target_armed[chan] = 1'b1;
                end
            end
            REQ_READBACK: begin
                if (chan < CHANNELS)
                    chan_level[chan] = code;
            end
            REQ_STEP: begin
                moved = 0;
                lim   = int'(max_step_cfg);
                for (int c = 0; c < CHANNELS; c++) begin
                    if (target_armed[c]) begin
                        delta = int'(chan_target[c]) - int'(chan_level[c]);
                        if (delta > lim)
                            delta = lim;
                        else if (delta < -lim)
                            delta = -lim;
                        if (delta != 0) begin
                            chan_level[c] = chan_level[c] + 16'(delta);
                            upd.chan      = 5'(c);
                            upd.level     = chan_level[c];
                            upd.last      = 1'b0;
                            upd.settled   = 1'b0;
                            level_updates.push_back(upd);
                            moved++;
                        end
                    end
                end
                if (moved == 0) begin
                    upd.chan    = '0;
                    upd.level   = '0;
                    upd.last    = 1'b0;
                    upd.settled = 1'b1;
                    level_updates.push_back(upd);
                end else begin
                    level_updates[level_updates.size() - 1].last = 1'b1;
                end
            end
            default: ;  // unused request code: no effect
        endcase
    endtask

    task automatic check_update();
        t_ramp_update want;
        if (level_updates.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual tdata 0x%0h tlast %0b tuser %0b",
                     $time, i_m_tdata, i_m_tlast, i_m_tuser);
            o_fail_count++;
        end else begin
            want = level_updates.pop_front();
            check_field("out_channel", 32'(want.chan), 32'(i_m_tdata[4:0]));
            check_field("new_level", 32'(want.level), 32'(i_m_tdata[20:5]));
            check_field("tdata padding", 32'd0, 32'(i_m_tdata[23:21]));
            check_field("last_update", 32'(want.last), 32'(i_m_tlast));
            check_field("settled", 32'(want.settled), 32'(i_m_tuser));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                chan_level[i]   = '0;
                chan_target[i]  = '0;
                target_armed[i] = 1'b0;
            end
            max_step_cfg = MAX_STEP_RST;
            level_updates.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                max_step_cfg = i_cfg_data;
            if (i_s_tvalid && i_s_tready)
                apply_request(i_s_tuser, i_s_tdata[4:0], i_s_tdata[20:5]);
            if (i_m_tvalid && i_m_tready)
                check_update();
        end
        o_outstanding = level_updates.size();
    end

endmodule

// ===== tb/tb_multichannel_bias_ramp_core.sv =====
// Testbench top for the bias ramp core: stimulus, stall patterns, watchdog and verdict.
module tb_multichannel_bias_ramp_core;
    import mcbr_pkg::*;

    localparam int CHANNELS       = CHANNELS_DEF;
    localparam int MAX_GAP        = 18;
    localparam int SETTLE_CYCLES  = CHANNELS + 8;   // one full walk plus pipeline slack
    localparam int HOLD_CYCLES    = 400;            // long output back-pressure stretch
    localparam int WATCHDOG_LIMIT = 4000;           // cycles without any transaction
    localparam int PHASE_ITEMS    = 28;

    // code the block does not define; must be dropped without effect
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;

    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;   // [4:0] channel, [20:5] value, [23:21] zero
    logic [1:0]  s_tuser = '0;   // [1:0] req_type

    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;        // [4:0] out_channel, [20:5] new_level, [23:21] zero
    logic        m_tlast;
    logic        m_tuser;        // [0] settled

    int          fail_count;
    int          outstanding;
    int          quiet_cycles = 0;

    // stall controls that the main sequence sets for the stimulus and the result sink
    bit          tx_idle = 1'b1;
    bit          rx_idle = 1'b1;
    bit          rx_hold_req = 1'b0;

    always #5 clk = ~clk;

    multichannel_bias_ramp_core #(
        .CHANNELS (CHANNELS)
    ) DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tlast   (m_tlast),
        .o_m_tuser   (m_tuser)
    );

    mcbr_ramp_checker #(
        .CHANNELS (CHANNELS)
    ) u_ramp_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tuser     (s_tuser),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_m_tlast     (m_tlast),
        .i_m_tuser     (m_tuser),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // Watchdog: any accepted transaction on any channel resets the count.
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d results still due", $time, outstanding);
            $display("multichannel_bias_ramp_core verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result sink: random ready gaps per result, plus one long hold on request.
    // tready is only lowered after a transaction, never lowered and raised in one step.
    initial begin : result_sink
        int gap;
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                gap = HOLD_CYCLES;
            end else begin
                gap = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    // Offer one request and wait for its transaction. tvalid stays high into the
    // next request when no gap is drawn.
    task automatic send_req(input logic [REQ_W-1:0] kind, input logic [CHAN_W-1:0] chan,
                            input logic [LEVEL_W-1:0] code);
        int gap;
        gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, code, chan};
        s_tuser  <= kind;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // Stop offering, let every due result drain and the walk finish, so the
    // block is idle for a register write.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_max_step(input logic [LEVEL_W-1:0] step);
        cfg_valid <= 1'b1;
        cfg_data  <= step;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic start_phase(input logic [LEVEL_W-1:0] step, input bit tx_gaps,
                               input bit rx_gaps);
        wait_idle();
        write_max_step(step);
        tx_idle = tx_gaps;
        rx_idle = rx_gaps;
    endtask

    // Codes biased toward the ends of the range and toward small values.
    function automatic logic [LEVEL_W-1:0] pick_code();
        case ($urandom_range(0, 4))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(0, 64));
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly arm-then-ramp sequences; some stray readbacks/steps and unused codes.
    task automatic run_random(input int n_items);
        int sent;
        int burst;
        int roll;
        sent = 0;
        while (sent < n_items) begin
            roll = $urandom_range(0, 9);
            if (roll < 7) begin
                burst = $urandom_range(1, 5);
                repeat (burst) send_req(REQ_SET_TARGET, 5'($urandom), pick_code());
                sent += burst;
                if ($urandom_range(0, 2) == 0) begin
                    send_req(REQ_READBACK, 5'($urandom), pick_code());
                    sent++;
                end
                burst = $urandom_range(1, 4);
                repeat (burst) send_req(REQ_STEP, 5'($urandom), 16'($urandom));
                sent += burst;
            end else if (roll < 9) begin
                send_req(roll == 7 ? REQ_READBACK : REQ_STEP, 5'($urandom), pick_code());
                sent++;
            end else begin
                // dropped by the block, so not counted
                send_req(REQ_UNUSED, 5'($urandom), 16'($urandom));
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset max_step (10): settled cases, channel/value extremes, unused code,
        // short ramp, target reached and held.
        send_req(REQ_STEP, 5'd0, 16'h0000);
        send_req(REQ_READBACK, 5'd0, 16'hFFFF);
        send_req(REQ_STEP, 5'd31, 16'hFFFF);
        send_req(REQ_SET_TARGET, 5'd0, 16'h0000);
        send_req(REQ_SET_TARGET, 5'd31, 16'hFFFF);
        send_req(REQ_UNUSED, 5'd5, 16'h1234);
        send_req(REQ_STEP, 5'd0, 16'h0000);
        send_req(REQ_SET_TARGET, 5'd7, 16'd3);
        send_req(REQ_STEP, 5'd0, 16'h0000);
        send_req(REQ_READBACK, 5'd31, 16'hFFFF);
        send_req(REQ_STEP, 5'd0, 16'h0000);

        // Largest step: everything lands on its target, then a settled step.
        // A readback then pulls a reached channel off its target.
        start_phase(16'hFFFF, 1'b0, 1'b0);
        send_req(REQ_STEP, 5'd0, 16'h0000);
        send_req(REQ_STEP, 5'd0, 16'h0000);
        send_req(REQ_READBACK, 5'd7, 16'd100);
        send_req(REQ_SET_TARGET, 5'd16, 16'h8000);

        // Zero step: nothing may move.
        start_phase(16'h0000, 1'b1, 1'b0);
        send_req(REQ_SET_TARGET, 5'd3, 16'hFFFF);
        send_req(REQ_STEP, 5'd0, 16'h0000);

        // Smallest nonzero step.
        start_phase(16'h0001, 1'b0, 1'b1);
        send_req(REQ_STEP, 5'd0, 16'h0000);
        send_req(REQ_STEP, 5'd0, 16'h0000);

        // Slow ramp with one long output hold: the block fills and stalls input.
        start_phase(16'd3, 1'b1, 1'b1);
        run_random(10);
        rx_hold_req = 1'b1;
        run_random(PHASE_ITEMS - 10);

        start_phase(16'($urandom_range(1, 65535)), 1'b1, 1'b1);
        run_random(PHASE_ITEMS);

        start_phase(16'($urandom_range(100, 4000)), 1'b0, 1'b1);
        run_random(PHASE_ITEMS);

        start_phase(16'($urandom_range(1, 64)), 1'b1, 1'b0);
        run_random(PHASE_ITEMS);

        wait_idle();
        if (fail_count == 0 && outstanding == 0) begin
            $display("multichannel_bias_ramp_core verification clean");
        end else begin
            $display("multichannel_bias_ramp_core verification failed");
        end
        $finish;
    end

endmodule
